// ===== rtl/bftic_pkg.sv =====
// Shared constants and types for the tape instruction core.
`timescale 1ns / 1ps

package bftic_pkg;

   localparam int TAPE_DEPTH_DEF  = 32768;
   localparam int STACK_DEPTH_DEF = 256;

   localparam logic [15:0] TAPE_SIZE_RST = 16'd32768;
   localparam logic [16:0] SKIP_MAX      = 17'h1FFFF;

   // Command bytes
   localparam logic [7:0] OP_RIGHT = 8'h3E;  // '>'
   localparam logic [7:0] OP_LEFT  = 8'h3C;  // '<'
   localparam logic [7:0] OP_INC   = 8'h2B;  // '+'
   localparam logic [7:0] OP_DEC   = 8'h2D;  // '-'
   localparam logic [7:0] OP_PUT   = 8'h2E;  // '.'
   localparam logic [7:0] OP_GET   = 8'h2C;  // ','
   localparam logic [7:0] OP_OPEN  = 8'h5B;  // '['
   localparam logic [7:0] OP_CLOSE = 8'h5D;  // ']'

   typedef enum logic [2:0] {
      FAULT_NONE       = 3'd0,
      FAULT_PAST_END   = 3'd1,
      FAULT_BELOW_ZERO = 3'd2,
      FAULT_STACK_FULL = 3'd3,
      FAULT_UNMATCHED  = 3'd4
   } fault_type;

endpackage

// ===== rtl/bftic_tape.sv =====
// Tape memory with post-reset clearing sweep and write-to-read forwarding.
`timescale 1ns / 1ps

module bftic_tape #(
   parameter int TAPE_DEPTH = bftic_pkg::TAPE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [$clog2(TAPE_DEPTH)-1:0] wr_addr,
   input  logic [7:0]                    wr_data,
   input  logic [$clog2(TAPE_DEPTH)-1:0] rd_addr,
   output logic [7:0]                    rd_data,
   output logic                          busy
);

   localparam int AW = $clog2(TAPE_DEPTH);

   logic [7:0]    mem [TAPE_DEPTH];
   logic          clr_ff;
   logic [AW-1:0] clr_addr_ff;
   logic [7:0]    rd_q_ff;
   logic          fwd_hit_ff;
   logic [7:0]    fwd_data_ff;

   logic          we;
   logic [AW-1:0] waddr;
   logic [7:0]    wdata;

   always_comb begin
      we    = clr_ff | wr_en;
      waddr = clr_ff ? clr_addr_ff : wr_addr;
      wdata = clr_ff ? 8'd0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(TAPE_DEPTH - 1)) begin
            clr_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read port sees old data on a same-address write; forward the new byte instead
   always_ff @(posedge clock) begin
      rd_q_ff     <= mem[rd_addr];
      fwd_hit_ff  <= we && (waddr == rd_addr);
      fwd_data_ff <= wdata;
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : rd_q_ff;
   assign busy    = clr_ff;

endmodule

// ===== rtl/bftic_stack.sv =====
// Loop stack memory with write-to-read forwarding.
`timescale 1ns / 1ps

module bftic_stack #(
   parameter int LOOP_STACK_DEPTH = bftic_pkg::STACK_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(LOOP_STACK_DEPTH)-1:0] wr_addr,
   input  logic [15:0]                         wr_data,
   input  logic [$clog2(LOOP_STACK_DEPTH)-1:0] rd_addr,
   output logic [15:0]                         rd_data
);

   logic [15:0] mem [LOOP_STACK_DEPTH];
   logic [15:0] rd_q_ff;
   logic        fwd_hit_ff;
   logic [15:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_q_ff     <= mem[rd_addr];
      fwd_hit_ff  <= wr_en && (wr_addr == rd_addr);
      fwd_data_ff <= wr_data;
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : rd_q_ff;

endmodule

// ===== rtl/bf_tape_instruction_core.sv =====
// Top level of the tape instruction core: execute stage and result register.
//
//   channel | dir | handshake              | payload
//   req_    | in  | req_valid / req_stall  | op, program_position, input_byte
//   rsp_    | out | rsp_valid / rsp_stall  | out_valid, out_byte, jump_valid,
//           |     |                        | jump_target, fault, skip_active
//   csr_    | in  | csr_valid / csr_ready  | tape_size
//
// One beat per cycle while req_stall is low; results pass execute and result registers.
// Both memories are read every cycle at the pointer/level the executing item leaves
// behind, so the next item finds its cell and stack top ready; same-entry writes are
// forwarded. After reset the tape is zeroed while req_stall is held.
// A stall on rsp_ backs up into the execute stage and then into req_stall.
`timescale 1ns / 1ps

module bf_tape_instruction_core #(
   parameter int TAPE_DEPTH       = bftic_pkg::TAPE_DEPTH_DEF,
   parameter int LOOP_STACK_DEPTH = bftic_pkg::STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_op,
   input  logic [15:0] req_program_position,
   input  logic [7:0]  req_input_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_out_valid,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_jump_valid,
   output logic [15:0] rsp_jump_target,
   output logic [2:0]  rsp_fault,
   output logic        rsp_skip_active,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_tape_size
);

   localparam int AW = $clog2(TAPE_DEPTH);
   localparam int SW = $clog2(LOOP_STACK_DEPTH);
   localparam int CW = (AW + 1 > 16) ? AW + 1 : 16;

   logic [15:0]          tape_size_ff;
   logic                 exec_valid_ff, exec_valid_in;
   logic [7:0]           ex_op_ff;
   logic [15:0]          ex_pos_ff;
   logic [7:0]           ex_inb_ff;
   logic [AW-1:0]        dp_ff, dp_in, dp_new;
   logic [SW-1:0]        level_ff, level_in, level_new;
   logic [16:0]          skip_ff, skip_in, skip_new;
   logic                 halted_ff, halted_in, halted_new;
   bftic_pkg::fault_type fault_code_ff, fault_code_in, fault_code_new;

   logic                 rsp_valid_ff;
   logic                 rsp_out_valid_ff, rsp_jump_valid_ff, rsp_skip_active_ff;
   logic [7:0]           rsp_out_byte_ff;
   logic [15:0]          rsp_jump_target_ff;
   bftic_pkg::fault_type rsp_fault_ff;

   logic                 commit, accept, tape_busy;
   logic [7:0]           cur_byte;
   logic [15:0]          stack_top;
   logic                 tape_wr, push;
   logic [7:0]           tape_wdata;
   logic                 r_out_valid, r_jump_valid;
   logic [7:0]           r_out_byte;
   logic [15:0]          r_jump_target;
   bftic_pkg::fault_type r_fault;
   logic [CW-1:0]        size_x, eff_size, dp_inc;

   assign commit    = exec_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = tape_busy || (exec_valid_ff && !commit);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      size_x = CW'(tape_size_ff);
      if (size_x == '0) begin
         eff_size = CW'(1);
      end else if (size_x > CW'(TAPE_DEPTH)) begin
         eff_size = CW'(TAPE_DEPTH);
      end else begin
         eff_size = size_x;
      end
      dp_inc = CW'(dp_ff) + CW'(1);
   end

   always_comb begin
      dp_new         = dp_ff;
      level_new      = level_ff;
      skip_new       = skip_ff;
      halted_new     = halted_ff;
      fault_code_new = fault_code_ff;
      r_out_valid    = 1'b0;
      r_out_byte     = 8'd0;
      r_jump_valid   = 1'b0;
      r_jump_target  = 16'd0;
      r_fault        = bftic_pkg::FAULT_NONE;
      tape_wr        = 1'b0;
      tape_wdata     = cur_byte;
      push           = 1'b0;
      if (halted_ff) begin
         r_fault = fault_code_ff;
      end else if (skip_ff != 17'd0) begin
         // skipping a loop body: only brackets count
         if (ex_op_ff == bftic_pkg::OP_OPEN) begin
            if (skip_ff != bftic_pkg::SKIP_MAX) begin
               skip_new = skip_ff + 17'd1;
            end
         end else if (ex_op_ff == bftic_pkg::OP_CLOSE) begin
            skip_new = skip_ff - 17'd1;
         end
      end else begin
         unique case (ex_op_ff)
            bftic_pkg::OP_RIGHT: begin
               if (dp_inc >= eff_size) begin
                  r_fault = bftic_pkg::FAULT_PAST_END;
               end else begin
                  dp_new = dp_ff + AW'(1);
               end
            end
            bftic_pkg::OP_LEFT: begin
               if (dp_ff == '0) begin
                  r_fault = bftic_pkg::FAULT_BELOW_ZERO;
               end else begin
                  dp_new = dp_ff - AW'(1);
               end
            end
            bftic_pkg::OP_INC: begin
               tape_wr    = 1'b1;
               tape_wdata = cur_byte + 8'd1;
            end
            bftic_pkg::OP_DEC: begin
               tape_wr    = 1'b1;
               tape_wdata = cur_byte - 8'd1;
            end
            bftic_pkg::OP_PUT: begin
               r_out_valid = 1'b1;
               r_out_byte  = cur_byte;
            end
            bftic_pkg::OP_GET: begin
               tape_wr    = 1'b1;
               tape_wdata = ex_inb_ff;
            end
            bftic_pkg::OP_OPEN: begin
               if (level_ff == SW'(LOOP_STACK_DEPTH - 1)) begin
                  r_fault = bftic_pkg::FAULT_STACK_FULL;
               end else if (cur_byte != 8'd0) begin
                  push      = 1'b1;
                  level_new = level_ff + SW'(1);
               end else begin
                  skip_new = 17'd1;
               end
            end
            bftic_pkg::OP_CLOSE: begin
               if (level_ff == '0) begin
                  r_fault = bftic_pkg::FAULT_UNMATCHED;
               end else begin
                  r_jump_valid  = 1'b1;
                  r_jump_target = stack_top;
                  level_new     = level_ff - SW'(1);
               end
            end
            default: begin
            end
         endcase
         if (r_fault != bftic_pkg::FAULT_NONE) begin
            halted_new     = 1'b1;
            fault_code_new = r_fault;
         end
      end
   end

   always_comb begin
      dp_in         = commit ? dp_new : dp_ff;
      level_in      = commit ? level_new : level_ff;
      skip_in       = commit ? skip_new : skip_ff;
      halted_in     = commit ? halted_new : halted_ff;
      fault_code_in = commit ? fault_code_new : fault_code_ff;
      if (accept) begin
         exec_valid_in = 1'b1;
      end else if (commit) begin
         exec_valid_in = 1'b0;
      end else begin
         exec_valid_in = exec_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tape_size_ff  <= bftic_pkg::TAPE_SIZE_RST;
         exec_valid_ff <= 1'b0;
         dp_ff         <= '0;
         level_ff      <= '0;
         skip_ff       <= 17'd0;
         halted_ff     <= 1'b0;
         fault_code_ff <= bftic_pkg::FAULT_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            tape_size_ff <= csr_tape_size;
         end
         exec_valid_ff <= exec_valid_in;
         dp_ff         <= dp_in;
         level_ff      <= level_in;
         skip_ff       <= skip_in;
         halted_ff     <= halted_in;
         fault_code_ff <= fault_code_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ex_op_ff  <= req_op;
         ex_pos_ff <= req_program_position;
         ex_inb_ff <= req_input_byte;
      end
      if (commit) begin
         rsp_out_valid_ff   <= r_out_valid;
         rsp_out_byte_ff    <= r_out_byte;
         rsp_jump_valid_ff  <= r_jump_valid;
         rsp_jump_target_ff <= r_jump_target;
         rsp_fault_ff       <= r_fault;
         rsp_skip_active_ff <= (skip_new != 17'd0);
      end
   end

   bftic_tape #(
      .TAPE_DEPTH (TAPE_DEPTH)
   ) u_tape (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (commit && tape_wr),
      .wr_addr (dp_ff),
      .wr_data (tape_wdata),
      .rd_addr (dp_in),
      .rd_data (cur_byte),
      .busy    (tape_busy)
   );

   bftic_stack #(
      .LOOP_STACK_DEPTH (LOOP_STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (commit && push),
      .wr_addr (level_ff + SW'(1)),
      .wr_data (ex_pos_ff),
      .rd_addr (level_in),
      .rd_data (stack_top)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_valid   = rsp_out_valid_ff;
   assign rsp_out_byte    = rsp_out_byte_ff;
   assign rsp_jump_valid  = rsp_jump_valid_ff;
   assign rsp_jump_target = rsp_jump_target_ff;
   assign rsp_fault       = rsp_fault_ff;
   assign rsp_skip_active = rsp_skip_active_ff;

endmodule

// ===== rtl/bftic_checker.sv =====
// Port-level checker for the tape instruction core, bound to the top level.
`timescale 1ns / 1ps

module bftic_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_out_valid,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_jump_valid,
   input logic [15:0] rsp_jump_target,
   input logic [2:0]  rsp_fault,
   input logic        rsp_skip_active
);

   logic       seen_fault_ff;
   logic [2:0] seen_code_ff;

   // remember the halting fault seen on the result channel
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_fault_ff <= 1'b0;
         seen_code_ff  <= bftic_pkg::FAULT_NONE;
      end else if (rsp_valid && !rsp_stall && !seen_fault_ff &&
                   rsp_fault != bftic_pkg::FAULT_NONE) begin
         seen_fault_ff <= 1'b1;
         seen_code_ff  <= rsp_fault;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_valid) &&
      $stable(rsp_out_byte) && $stable(rsp_jump_valid) && $stable(rsp_jump_target) &&
      $stable(rsp_fault) && $stable(rsp_skip_active))
      else $error("result beat changed while stalled");

   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_fault != bftic_pkg::FAULT_NONE || rsp_jump_valid) |->
      !rsp_out_valid && !(rsp_jump_valid && rsp_fault != bftic_pkg::FAULT_NONE))
      else $error("fault, jump and output byte reported together");

   a_sticky: assert property (@(posedge clock) disable iff (reset)
      seen_fault_ff && rsp_valid |-> rsp_fault == seen_code_ff &&
      !rsp_out_valid && !rsp_jump_valid)
      else $error("halted core reported a different result");

   a_clear: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("request taken during tape clearing");

endmodule

bind bf_tape_instruction_core bftic_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_valid   (rsp_out_valid),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_jump_valid  (rsp_jump_valid),
   .rsp_jump_target (rsp_jump_target),
   .rsp_fault       (rsp_fault),
   .rsp_skip_active (rsp_skip_active)
);

// ===== verif/tb.sv =====
// Self-checking testbench for the tape instruction core.
`timescale 1ns / 1ps

module tb;
   import bftic_pkg::*;

   localparam int TAPE_CELLS     = TAPE_DEPTH_DEF;
   localparam int STACK_SLOTS    = STACK_DEPTH_DEF;
   localparam int N_DIRECTED     = 26;
   localparam int N_SEGMENTS     = 6;
   localparam int SEG_BEATS      = 180;
   localparam int PROG_MAX       = 32;
   localparam int PROG_STEP_CAP  = 120;
   localparam int DRAIN_CYCLES   = 20;
   localparam int TIMEOUT_CYCLES = 600000;

   typedef struct packed {
      logic        out_valid;
      logic [7:0]  out_byte;
      logic        jump_valid;
      logic [15:0] jump_target;
      fault_type   fault;
      logic        skip_active;
   } core_result_type;

   typedef struct packed {
      logic [7:0]      op;
      logic [15:0]     pos;
      logic [7:0]      inb;
      logic            typed;
      core_result_type res;
   } tape_vector_type;

   localparam core_result_type QUIET = '0;

   localparam logic [7:0] COMMANDS [8] = '{OP_RIGHT, OP_LEFT, OP_INC, OP_DEC,
                                            OP_PUT, OP_GET, OP_OPEN, OP_CLOSE};
   // loop bodies lean toward '-' so most loops run out
   localparam logic [7:0] BODY_OPS [7] = '{OP_INC, OP_DEC, OP_DEC, OP_RIGHT,
                                            OP_LEFT, OP_PUT, OP_GET};

   localparam logic [15:0] SEG_SIZES [N_SEGMENTS] = '{16'hFFFF, 16'd3, 16'd1,
                                                      16'd32768, 16'd0, 16'd0};

   logic        clock;
   logic        reset                = 1'b1;
   logic        req_valid            = 1'b0;
   logic        req_stall;
   logic [7:0]  req_op               = 8'h00;
   logic [15:0] req_program_position = 16'h0000;
   logic [7:0]  req_input_byte       = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall            = 1'b0;
   logic        rsp_out_valid;
   logic [7:0]  rsp_out_byte;
   logic        rsp_jump_valid;
   logic [15:0] rsp_jump_target;
   logic [2:0]  rsp_fault;
   logic        rsp_skip_active;
   logic        csr_valid            = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_tape_size        = 16'h0000;

   bf_tape_instruction_core u_top (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Shadow copy of the core state
   logic [7:0]  cell_mem  [TAPE_CELLS];
   logic [15:0] frame_mem [STACK_SLOTS];
   int unsigned ptr_m;
   int unsigned level_m;
   logic [16:0] skip_m;
   logic        halted_m;
   fault_type   halt_code_m;
   logic [15:0] size_m;

   core_result_type pending_results [$];
   core_result_type want;
   tape_vector_type directed_vecs [N_DIRECTED];

   int send_idle;
   int recv_idle;
   int beats_sent;
   int results_checked;
   int mismatches;
   int cycle_count;
   fault_type final_code;

   function automatic core_result_type result_of(input logic ov, input logic [7:0] ob,
                                                 input logic jv, input logic [15:0] jt,
                                                 input fault_type f, input logic sk);
      core_result_type r;
      r.out_valid   = ov;
      r.out_byte    = ob;
      r.jump_valid  = jv;
      r.jump_target = jt;
      r.fault       = f;
      r.skip_active = sk;
      return r;
   endfunction

   function automatic int unsigned usable_cells();
      if (size_m == 16'd0) return 1;
      if (size_m > TAPE_CELLS) return TAPE_CELLS;
      return size_m;
   endfunction

   // Executes one program byte on the shadow state and returns its result beat.
   function automatic core_result_type run_tape_op(input logic [7:0] op,
                                                   input logic [15:0] pos,
                                                   input logic [7:0] inb);
      core_result_type r;
      r = QUIET;
      if (halted_m) begin
         r.fault = halt_code_m;
      end else if (skip_m != 0) begin
         if (op == OP_OPEN && skip_m != SKIP_MAX) skip_m = skip_m + 1;
         else if (op == OP_CLOSE) skip_m = skip_m - 1;
      end else begin
         case (op)
            OP_RIGHT: begin
               if (ptr_m + 1 >= usable_cells()) r.fault = FAULT_PAST_END;
               else ptr_m = ptr_m + 1;
            end
            OP_LEFT: begin
               if (ptr_m == 0) r.fault = FAULT_BELOW_ZERO;
               else ptr_m = ptr_m - 1;
            end
            OP_INC: cell_mem[ptr_m] = cell_mem[ptr_m] + 8'd1;
            OP_DEC: cell_mem[ptr_m] = cell_mem[ptr_m] - 8'd1;
            OP_PUT: begin
               r.out_valid = 1'b1;
               r.out_byte  = cell_mem[ptr_m];
            end
            OP_GET: cell_mem[ptr_m] = inb;
            OP_OPEN: begin
               if (level_m >= STACK_SLOTS - 1) begin
                  r.fault = FAULT_STACK_FULL;
               end else if (cell_mem[ptr_m] != 8'd0) begin
                  level_m = level_m + 1;
                  frame_mem[level_m] = pos;
               end else begin
                  skip_m = 17'd1;
               end
            end
            OP_CLOSE: begin
               if (level_m == 0) begin
                  r.fault = FAULT_UNMATCHED;
               end else begin
                  r.jump_valid  = 1'b1;
                  r.jump_target = frame_mem[level_m];
                  level_m = level_m - 1;
               end
            end
            default: ;
         endcase
         if (r.fault != FAULT_NONE) begin
            halted_m    = 1'b1;
            halt_code_m = r.fault;
         end
      end
      r.skip_active = (skip_m != 0);
      return r;
   endfunction

   // Random stimulus stays clear of faults until the closing phase.
   function automatic bit faults_now(input logic [7:0] op);
      if (halted_m || skip_m != 0) return 1'b0;
      case (op)
         OP_RIGHT: return ptr_m + 1 >= usable_cells();
         OP_LEFT:  return ptr_m == 0;
         OP_OPEN:  return level_m >= STACK_SLOTS - 1;
         OP_CLOSE: return level_m == 0;
         default:  return 1'b0;
      endcase
   endfunction

   function automatic logic [7:0] pick_input();
      return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
   endfunction

   task automatic set_pace(input int mode);
      case (mode)
         0: begin
            send_idle = 35;
            recv_idle = 73;
         end
         1: begin
            send_idle = 73;
            recv_idle = 35;
         end
         default: begin
            send_idle = 0;
            recv_idle = 0;
         end
      endcase
   endtask

   task automatic send_beat(input logic [7:0] op, input logic [15:0] pos, input logic [7:0] inb,
                            input logic typed, input core_result_type typed_res,
                            output core_result_type predicted);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_op               <= op;
      req_program_position <= pos;
      req_input_byte       <= inb;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = run_tape_op(op, pos, inb);
      pending_results.push_back(typed ? typed_res : predicted);
      beats_sent++;
   endtask

   task automatic write_tape_size(input logic [15:0] value);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      csr_valid     <= 1'b1;
      csr_tape_size <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      size_m = value;
      csr_valid <= 1'b0;
   endtask

   task automatic send_noise();
      logic [7:0] op;
      core_result_type r;
      op = $urandom_range(0, 1) ? 8'($urandom) : COMMANDS[$urandom_range(0, 7)];
      if (faults_now(op)) op = OP_PUT;
      send_beat(op, 16'($urandom), pick_input(), 1'b0, QUIET, r);
   endtask

   // Builds a balanced random program and fetches it, following predicted jumps.
   task automatic run_program(input int stop_at);
      logic [7:0]      prog [PROG_MAX];
      logic [15:0]     base;
      core_result_type r;
      int len;
      int depth;
      int target;
      int pc;
      int steps;
      int next_pc;
      len    = 0;
      depth  = 0;
      target = $urandom_range(4, 24);
      while (len < target) begin
         case ($urandom_range(0, 9))
            0: begin
               if (depth < 4) begin
                  prog[len] = OP_OPEN;
                  depth++;
               end else begin
                  prog[len] = OP_DEC;
               end
            end
            1: begin
               if (depth > 0) begin
                  prog[len] = OP_CLOSE;
                  depth--;
               end else begin
                  prog[len] = OP_INC;
               end
            end
            default: prog[len] = BODY_OPS[$urandom_range(0, 6)];
         endcase
         len++;
      end
      while (depth > 0) begin
         prog[len] = OP_CLOSE;
         len++;
         depth--;
      end
      base  = 16'($urandom_range(0, 16'hFFFF - PROG_MAX));
      pc    = 0;
      steps = 0;
      while (pc < len && steps < PROG_STEP_CAP && beats_sent < stop_at) begin
         if (faults_now(prog[pc])) break;
         send_beat(prog[pc], base + 16'(pc), pick_input(), 1'b0, QUIET, r);
         steps++;
         next_pc = r.jump_valid ? int'(r.jump_target) - int'(base) : pc + 1;
         // a leftover frame from an abandoned program points elsewhere
         if (next_pc < 0 || next_pc > len) break;
         pc = next_pc;
      end
   endtask

   // Drives the core into one fault, then checks that it stays halted.
   task automatic end_with_fault();
      core_result_type r;
      fault_type kind;
      kind = fault_type'($urandom_range(1, 4));
      final_code = kind;
      while (skip_m != 0) send_beat(OP_CLOSE, 16'($urandom), pick_input(), 1'b0, QUIET, r);
      case (kind)
         FAULT_PAST_END: begin
            write_tape_size(16'($urandom_range(0, 8)));
            do begin
               send_beat(OP_RIGHT, 16'($urandom), pick_input(), 1'b0, QUIET, r);
            end while (r.fault == FAULT_NONE);
         end
         FAULT_BELOW_ZERO: begin
            do begin
               send_beat(OP_LEFT, 16'($urandom), pick_input(), 1'b0, QUIET, r);
            end while (r.fault == FAULT_NONE);
         end
         FAULT_STACK_FULL: begin
            if (cell_mem[ptr_m] == 8'd0)
               send_beat(OP_GET, 16'($urandom), 8'($urandom_range(1, 255)), 1'b0, QUIET, r);
            do begin
               send_beat(OP_OPEN, 16'($urandom), pick_input(), 1'b0, QUIET, r);
            end while (r.fault == FAULT_NONE);
         end
         default: begin
            do begin
               send_beat(OP_CLOSE, 16'($urandom), pick_input(), 1'b0, QUIET, r);
            end while (r.fault == FAULT_NONE);
         end
      endcase
      repeat (8) send_noise();
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d results still pending",
                  cycle_count, pending_results.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Result side: random stall, compare every accepted beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset) begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle);
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result beat with nothing pending");
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               results_checked++;
               if (rsp_out_valid !== want.out_valid) begin
                  $error("out_valid: expected %0d, got %0d", want.out_valid, rsp_out_valid);
                  mismatches++;
               end
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte: expected %0h, got %0h", want.out_byte, rsp_out_byte);
                  mismatches++;
               end
               if (rsp_jump_valid !== want.jump_valid) begin
                  $error("jump_valid: expected %0d, got %0d", want.jump_valid, rsp_jump_valid);
                  mismatches++;
               end
               if (rsp_jump_target !== want.jump_target) begin
                  $error("jump_target: expected %0h, got %0h",
                         want.jump_target, rsp_jump_target);
                  mismatches++;
               end
               if (rsp_fault !== want.fault) begin
                  $error("fault: expected %0d, got %0d", want.fault, rsp_fault);
                  mismatches++;
               end
               if (rsp_skip_active !== want.skip_active) begin
                  $error("skip_active: expected %0d, got %0d",
                         want.skip_active, rsp_skip_active);
                  mismatches++;
               end
            end
         end
      end
   end

   initial begin
      core_result_type r;
      int seg_end;
      logic [15:0] seg_size;

      beats_sent      = 0;
      results_checked = 0;
      mismatches      = 0;
      final_code      = FAULT_NONE;
      foreach (cell_mem[i]) cell_mem[i] = 8'h00;
      foreach (frame_mem[i]) frame_mem[i] = 16'h0000;
      ptr_m       = 0;
      level_m     = 0;
      skip_m      = '0;
      halted_m    = 1'b0;
      halt_code_m = FAULT_NONE;
      size_m      = TAPE_SIZE_RST;
      set_pace(0);

      directed_vecs = '{
         // fresh tape reads zero, '-' wraps down, '+' wraps up
         '{OP_PUT,   16'h0000, 8'h00, 1'b1, result_of(1, 8'h00, 0, 16'h0, FAULT_NONE, 0)},
         '{OP_DEC,   16'hFFFF, 8'hFF, 1'b1, QUIET},
         '{OP_PUT,   16'h0001, 8'h00, 1'b1, result_of(1, 8'hFF, 0, 16'h0, FAULT_NONE, 0)},
         '{OP_INC,   16'h0002, 8'h00, 1'b1, QUIET},
         '{OP_PUT,   16'h0003, 8'hFF, 1'b1, result_of(1, 8'h00, 0, 16'h0, FAULT_NONE, 0)},
         '{OP_GET,   16'h0004, 8'hFF, 1'b1, QUIET},
         '{OP_INC,   16'h0005, 8'h00, 1'b1, QUIET},
         '{OP_PUT,   16'h0006, 8'h00, 1'b1, result_of(1, 8'h00, 0, 16'h0, FAULT_NONE, 0)},
         '{OP_GET,   16'h0007, 8'h80, 1'b1, QUIET},
         // neighbor cell is still zero
         '{OP_RIGHT, 16'h0008, 8'h00, 1'b1, QUIET},
         '{OP_PUT,   16'h0009, 8'h00, 1'b1, result_of(1, 8'h00, 0, 16'h0, FAULT_NONE, 0)},
         '{OP_LEFT,  16'h000A, 8'h00, 1'b1, QUIET},
         '{OP_PUT,   16'h000B, 8'h00, 1'b1, result_of(1, 8'h80, 0, 16'h0, FAULT_NONE, 0)},
         // nested loops on a nonzero cell: push two frames, pop in reverse
         '{OP_OPEN,  16'hFFFF, 8'h00, 1'b1, QUIET},
         '{OP_OPEN,  16'h8001, 8'h7F, 1'b1, QUIET},
         '{OP_CLOSE, 16'h8002, 8'h00, 1'b1, result_of(0, 8'h00, 1, 16'h8001, FAULT_NONE, 0)},
         '{OP_CLOSE, 16'h8003, 8'h00, 1'b1, result_of(0, 8'h00, 1, 16'hFFFF, FAULT_NONE, 0)},
         // zero cell: skip a nested body, nothing inside executes
         '{OP_GET,   16'h0010, 8'h00, 1'b1, QUIET},
         '{OP_OPEN,  16'h0011, 8'h00, 1'b1, result_of(0, 8'h00, 0, 16'h0, FAULT_NONE, 1)},
         '{OP_OPEN,  16'h0012, 8'h00, 1'b1, result_of(0, 8'h00, 0, 16'h0, FAULT_NONE, 1)},
         '{OP_INC,   16'h0013, 8'h00, 1'b1, result_of(0, 8'h00, 0, 16'h0, FAULT_NONE, 1)},
         '{OP_CLOSE, 16'h0014, 8'h00, 1'b1, result_of(0, 8'h00, 0, 16'h0, FAULT_NONE, 1)},
         '{OP_CLOSE, 16'h0015, 8'h00, 1'b1, QUIET},
         '{OP_PUT,   16'h0016, 8'h00, 1'b1, result_of(1, 8'h00, 0, 16'h0, FAULT_NONE, 0)},
         '{8'h00,    16'h0017, 8'h55, 1'b0, QUIET},
         '{8'hFF,    16'hAAAA, 8'hAA, 1'b0, QUIET}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_vecs[i])
         send_beat(directed_vecs[i].op, directed_vecs[i].pos, directed_vecs[i].inb,
                   directed_vecs[i].typed, directed_vecs[i].res, r);

      for (int s = 0; s < N_SEGMENTS; s++) begin
         set_pace(s / 2);
         seg_size = (s == 4) ? 16'($urandom_range(2, 64)) : SEG_SIZES[s];
         write_tape_size(seg_size);
         seg_end = N_DIRECTED + (s + 1) * SEG_BEATS;
         while (beats_sent < seg_end) begin
            if ($urandom_range(0, 9) < 7) run_program(seg_end);
            else send_noise();
         end
      end

      end_with_fault();
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d instruction beats (%0d directed) under three pacing mixes,",
               beats_sent, N_DIRECTED);
      $display("tape size 0..65535; checked %0d results with %0d mismatches, halt code %0d.",
               results_checked, mismatches, final_code);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
